### rtl/adc_group_adaptive_smoother_macros.svh
// Assertion macros shared by the checker file of the ADC group smoother.
`ifndef ADC_GROUP_ADAPTIVE_SMOOTHER_MACROS_SVH
`define ADC_GROUP_ADAPTIVE_SMOOTHER_MACROS_SVH

// Clocked assertion, switched off while reset is low
`define ADCS_ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds across reset
`define ADCS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/adcs_pkg.sv
// Package of the ADC group smoother: widths, constants and shared types.
`default_nettype none

package adcs_pkg;

    // Sample path
    localparam int SAMPLE_WIDTH  = 12;
    localparam int GROUP_SIZE    = 8;
    localparam int GROUP_SHIFT   = $clog2(GROUP_SIZE);
    localparam int CNT_WIDTH     = $clog2(GROUP_SIZE);
    localparam int SUM_WIDTH     = SAMPLE_WIDTH + GROUP_SHIFT;
    localparam int CHANNEL_COUNT = 3;
    localparam int CH_WIDTH      = 2;

    // Filter arithmetic, state is Q12.8
    localparam int FRAC_BITS     = 8;
    localparam int STATE_WIDTH   = SAMPLE_WIDTH + FRAC_BITS;
    localparam int SHOWN_WIDTH   = SAMPLE_WIDTH + 1;
    localparam int GAIN_WIDTH    = 9;
    localparam int GAIN_SHIFT    = 9;
    localparam int DIFF_WIDTH    = STATE_WIDTH + 1;
    localparam int PROD_WIDTH    = DIFF_WIDTH + GAIN_WIDTH + 1;
    localparam int NEXT_WIDTH    = PROD_WIDTH - GAIN_SHIFT;

    localparam logic [GAIN_WIDTH-1:0] GAIN_MAX  = GAIN_WIDTH'(256);
    localparam logic [FRAC_BITS-1:0]  FRAC_HIGH = FRAC_BITS'(180);
    localparam logic [FRAC_BITS-1:0]  FRAC_LOW  = FRAC_BITS'(77);

    // Group queue between front and back
    localparam int QUEUE_DEPTH   = 4;
    localparam int QPTR_WIDTH    = $clog2(QUEUE_DEPTH);
    localparam int QCNT_WIDTH    = QPTR_WIDTH + 1;

    // One finished group
    typedef struct packed {
        logic [CH_WIDTH-1:0]     channel;
        logic [SAMPLE_WIDTH-1:0] avg;
    } t_group;

    // Queue status seen by both sides
    typedef struct packed {
        logic full;
        logic empty;
    } t_queue_status;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_PREP,
        BK_MUL,
        BK_DONE
    } t_back_state;

endpackage

`default_nettype wire

### rtl/adcs_front.sv
// Front end: accumulates samples per group and hands finished groups on.
`default_nettype none

module adcs_front
    import adcs_pkg::*;
(
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_accept,
    input  wire logic [SAMPLE_WIDTH-1:0] i_sample,
    output logic                         o_group_push,
    output t_group                       o_group
);

    logic [CNT_WIDTH-1:0] r_count, n_count;
    logic [SUM_WIDTH-1:0] r_sum, n_sum;
    logic [CH_WIDTH-1:0]  r_channel, n_channel;
    logic [SUM_WIDTH-1:0] sum_total;
    logic                 last;

    // Group end detection and next values
    always_comb begin
        sum_total = r_sum + SUM_WIDTH'(i_sample);
        last      = (r_count == CNT_WIDTH'(GROUP_SIZE - 1));
        n_count   = r_count;
        n_sum     = r_sum;
        n_channel = r_channel;
        if (i_accept) begin
            if (last) begin
                n_count = '0;
                n_sum   = '0;
                if (r_channel == CH_WIDTH'(CHANNEL_COUNT - 1)) begin
                    n_channel = '0;
                end else begin
                    n_channel = r_channel + 1'b1;
                end
            end else begin
                n_count = r_count + 1'b1;
                n_sum   = sum_total;
            end
        end
    end

    assign o_group_push  = i_accept && last;
    assign o_group.channel = r_channel;
    assign o_group.avg     = SAMPLE_WIDTH'(sum_total >> GROUP_SHIFT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_sum     <= '0;
            r_channel <= '0;
        end else begin
            r_count   <= n_count;
            r_sum     <= n_sum;
            r_channel <= n_channel;
        end
    end

endmodule

`default_nettype wire

### rtl/adcs_queue.sv
// Short queue of finished groups between front and back.
`default_nettype none

module adcs_queue
    import adcs_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_push,
    input  wire t_group  i_group,
    input  wire logic    i_pop,
    output t_group       o_group,
    output t_queue_status o_status
);

    t_group                r_mem [QUEUE_DEPTH];
    logic [QPTR_WIDTH-1:0] r_wr_ptr;
    logic [QPTR_WIDTH-1:0] r_rd_ptr;
    logic [QCNT_WIDTH-1:0] r_fill;
    logic                  do_push;
    logic                  do_pop;

    assign o_status.full  = (r_fill == QCNT_WIDTH'(QUEUE_DEPTH));
    assign o_status.empty = (r_fill == '0);
    assign do_push = i_push && !o_status.full;
    assign do_pop  = i_pop && !o_status.empty;
    assign o_group = r_mem[r_rd_ptr];

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_group;
        end
    end

    // Pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_fill <= r_fill + 1'b1;
                2'b01:   r_fill <= r_fill - 1'b1;
                default: r_fill <= r_fill;
            endcase
        end
    end

endmodule

`default_nettype wire

### rtl/adcs_back.sv
// Back end: per-channel adaptive filter, hysteretic rounding and result register.
`default_nettype none

module adcs_back
    import adcs_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire t_group                 i_group,
    input  wire t_queue_status          i_status,
    output logic                        o_group_pop,
    input  wire logic                   i_pop,
    output logic                        o_empty,
    output logic [CH_WIDTH-1:0]         o_channel,
    output logic [SHOWN_WIDTH-1:0]      o_shown_value
);

    t_back_state r_state, n_state;

    // Per-channel state
    logic [STATE_WIDTH-1:0] r_filter [CHANNEL_COUNT];
    logic [SHOWN_WIDTH-1:0] r_shown  [CHANNEL_COUNT];
    logic                   r_flag   [CHANNEL_COUNT];

    // Working registers of the item in flight
    logic [CH_WIDTH-1:0]          r_ch;
    logic [SAMPLE_WIDTH-1:0]      r_avg;
    logic [GAIN_WIDTH-1:0]        r_gain;
    logic signed [DIFF_WIDTH-1:0] r_diff;
    logic signed [PROD_WIDTH-1:0] r_prod;

    // Result register
    logic                   r_out_valid;
    logic [CH_WIDTH-1:0]    r_out_ch;
    logic [SHOWN_WIDTH-1:0] r_out_shown;

    logic [STATE_WIDTH-1:0]       cur_state;
    logic [SHOWN_WIDTH-1:0]       cur_shown;
    logic                         cur_flag;
    logic [SHOWN_WIDTH-1:0]       avg_ext;
    logic [SHOWN_WIDTH-1:0]       distance;
    logic [GAIN_WIDTH-1:0]        gain;
    logic signed [DIFF_WIDTH-1:0] diff;
    logic signed [NEXT_WIDTH-1:0] step;
    logic signed [NEXT_WIDTH-1:0] sum_next;
    logic [STATE_WIDTH-1:0]       new_state;
    logic [FRAC_BITS-1:0]         frac;
    logic [SHOWN_WIDTH-1:0]       new_shown;
    logic                         new_flag;
    logic                         out_free;
    logic                         commit;

    assign out_free = !r_out_valid || i_pop;
    assign commit   = (r_state == BK_DONE) && out_free;

    // Sequencer: take a group, form gain and error, multiply, commit
    always_comb begin
        n_state     = r_state;
        o_group_pop = 1'b0;
        case (r_state)
            BK_IDLE: begin
                if (!i_status.empty) begin
                    o_group_pop = 1'b1;
                    n_state     = BK_PREP;
                end
            end
            BK_PREP: n_state = BK_MUL;
            BK_MUL:  n_state = BK_DONE;
            BK_DONE: begin
                if (out_free) begin
                    n_state = BK_IDLE;
                end
            end
            default: n_state = BK_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BK_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Gain and error from the stored state of the channel
    always_comb begin
        cur_state = r_filter[r_ch];
        cur_shown = r_shown[r_ch];
        cur_flag  = r_flag[r_ch];
        avg_ext   = SHOWN_WIDTH'(r_avg);
        if (avg_ext >= cur_shown) begin
            distance = avg_ext - cur_shown;
        end else begin
            distance = cur_shown - avg_ext;
        end
        if (distance > SHOWN_WIDTH'(GAIN_MAX)) begin
            gain = GAIN_MAX;
        end else begin
            gain = GAIN_WIDTH'(distance);
        end
        diff = $signed({1'b0, r_avg, {FRAC_BITS{1'b0}}}) - $signed({1'b0, cur_state});
    end

    // State update and hysteretic rounding; the shift floors toward minus infinity
    always_comb begin
        step     = r_prod[PROD_WIDTH-1:GAIN_SHIFT];
        sum_next = $signed({{(NEXT_WIDTH-STATE_WIDTH){1'b0}}, cur_state}) + step;
        if (sum_next[NEXT_WIDTH-1]) begin
            new_state = '0;
        end else begin
            new_state = sum_next[STATE_WIDTH-1:0];
        end
        frac      = new_state[FRAC_BITS-1:0];
        new_shown = SHOWN_WIDTH'(new_state[STATE_WIDTH-1:FRAC_BITS]);
        new_flag  = cur_flag;
        if (frac >= FRAC_HIGH) begin
            new_shown = new_shown + 1'b1;
            new_flag  = 1'b1;
        end else if (frac >= FRAC_LOW) begin
            if (cur_flag) begin
                new_shown = new_shown + 1'b1;
            end
        end else begin
            new_flag = 1'b0;
        end
    end

    // Datapath registers of the item in flight
    always_ff @(posedge i_clk) begin
        if (o_group_pop) begin
            r_ch  <= i_group.channel;
            r_avg <= i_group.avg;
        end
        if (r_state == BK_PREP) begin
            r_gain <= gain;
            r_diff <= diff;
        end
        if (r_state == BK_MUL) begin
            r_prod <= $signed({1'b0, r_gain}) * r_diff;
        end
    end

    // Per-channel state, written when the result goes out
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < CHANNEL_COUNT; i++) begin
                r_filter[i] <= '0;
                r_shown[i]  <= '0;
                r_flag[i]   <= 1'b0;
            end
        end else if (commit) begin
            r_filter[r_ch] <= new_state;
            r_shown[r_ch]  <= new_shown;
            r_flag[r_ch]   <= new_flag;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (commit) begin
            r_out_valid <= 1'b1;
        end else if (i_pop) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (commit) begin
            r_out_ch    <= r_ch;
            r_out_shown <= new_shown;
        end
    end

    assign o_empty       = !r_out_valid;
    assign o_channel     = r_out_ch;
    assign o_shown_value = r_out_shown;

endmodule

`default_nettype wire

### rtl/adc_group_adaptive_smoother.sv
// Top level of the ADC group smoother: front end, group queue and filter back end.
//
// Samples are taken one per cycle while full is low, eight to a group, with the
// groups in channel rotation 0, 1, 2. The front end keeps the running sum and,
// on the eighth sample, pushes the channel and floor average into a four-entry
// group queue. The back end handles one group at a time in the steps take, gain
// and error, multiply and update, through a single 10x21-bit multiplier and a
// result register. Because groups end at most once every eight samples, the back
// end keeps up with full sample rate; if results are not popped, the queue fills
// after four more groups and full is raised until room frees up. Channel state
// resets to zero.
`default_nettype none

module adc_group_adaptive_smoother
    import adcs_pkg::*;
(
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_push,
    output logic                         o_full,
    input  wire logic [SAMPLE_WIDTH-1:0] i_sample,
    output logic                         o_empty,
    input  wire logic                    i_pop,
    output logic [CH_WIDTH-1:0]          o_channel,
    output logic [SHOWN_WIDTH-1:0]       o_shown_value
);

    t_group        front_group;
    t_group        queue_group;
    t_queue_status queue_status;
    logic          group_push;
    logic          group_pop;
    logic          accept;

    assign o_full = queue_status.full;
    assign accept = i_push && !queue_status.full;

    adcs_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_sample     (i_sample),
        .o_group_push (group_push),
        .o_group      (front_group)
    );

    adcs_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (group_push),
        .i_group  (front_group),
        .i_pop    (group_pop),
        .o_group  (queue_group),
        .o_status (queue_status)
    );

    adcs_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_group       (queue_group),
        .i_status      (queue_status),
        .o_group_pop   (group_pop),
        .i_pop         (i_pop),
        .o_empty       (o_empty),
        .o_channel     (o_channel),
        .o_shown_value (o_shown_value)
    );

endmodule

`default_nettype wire

### rtl/adcs_checker.sv
// Port-level checker of the ADC group smoother and its bind.
`default_nettype none

`include "adc_group_adaptive_smoother_macros.svh"

module adcs_checker
    import adcs_pkg::*;
(
    input wire logic                   i_clk,
    input wire logic                   i_rst_n,
    input wire logic                   o_empty,
    input wire logic                   i_pop,
    input wire logic [CH_WIDTH-1:0]    o_channel,
    input wire logic [SHOWN_WIDTH-1:0] o_shown_value
);

    // Reset leaves no result waiting
    `ADCS_ASSERT_ALWAYS(a_reset_empty, i_clk, (!i_rst_n) |=> o_empty, "result after reset")

    // Only real channels are reported
    `ADCS_ASSERT_CLK(a_channel_range, i_clk, i_rst_n, (!o_empty) |-> (o_channel != 2'd3), "bad channel")

    // Shown value never exceeds full scale plus one rounding step
    `ADCS_ASSERT_CLK(a_shown_range, i_clk, i_rst_n, (!o_empty) |-> (o_shown_value <= 13'd4096), "shown value out of range")

    // A waiting result holds until popped
    `ADCS_ASSERT_CLK(a_result_hold, i_clk, i_rst_n, (!o_empty && !i_pop) |=> (!o_empty && $stable(o_shown_value) && $stable(o_channel)), "result changed while waiting")

endmodule

bind adc_group_adaptive_smoother adcs_checker u_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_empty       (o_empty),
    .i_pop         (i_pop),
    .o_channel     (o_channel),
    .o_shown_value (o_shown_value)
);

`default_nettype wire
